// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the solver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, sampled on clk, off during rst
`define QRS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/qrs_pkg.sv =====
// shared widths, kind codes and item types of the quadratic root solver
package qrs_pkg;
  localparam int COEF_W      = 16;
  localparam int FRAC_OUT    = 16;
  localparam int OUT_W       = 32;
  localparam int DMAG_W      = 2 * COEF_W + 2;
  localparam int ROOT_W      = DMAG_W / 2 + FRAC_OUT;
  localparam int REM_W       = ROOT_W + 2;
  localparam int NUM_W       = ROOT_W + 2;
  localparam int DEN_W       = COEF_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    KIND_LINEAR     = 3'd0,
    KIND_REPEATED   = 3'd1,
    KIND_TWO_REAL   = 3'd2,
    KIND_COMPLEX    = 3'd3,
    KIND_DEGENERATE = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
    logic signed [COEF_W-1:0]  c;
    logic        [DMAG_W-1:0]  dmag;
  } item_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [OUT_W-1:0]  first;
    logic signed [OUT_W-1:0]  second;
    logic                     sat;
  } result_t;
endpackage

// ===== hw/rtl/quadratic_root_solver_core.sv =====
// top level of the quadratic root solver: front, queue and back end
// throughput: one beat per cycle unless the back end holds, set by the root and
// divider pipes of one bit per stage; the back end holds as a whole only while the
// two-entry result queue is full and its last divider stage holds a beat
// reset: rst is synchronous; it empties both queues and clears all stage valids
module quadratic_root_solver_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
  input  logic                              pop,
  output logic                              empty,
  output logic [2:0]                        root_kind,
  output logic signed [qrs_pkg::OUT_W-1:0]  first_value,
  output logic signed [qrs_pkg::OUT_W-1:0]  second_value,
  output logic                              saturated
);
  qrs_pkg::item_t   f_item, q_item;
  qrs_pkg::result_t res;
  logic             q_full, q_empty, q_pop, wr_en;

  assign full  = q_full;
  assign wr_en = push && !q_full;

  qrs_front u_front (
    .coef_a (coef_a),
    .coef_b (coef_b),
    .coef_c (coef_c),
    .item   (f_item)
  );

  qrs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_item (f_item),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  qrs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign root_kind    = res.kind;
  assign first_value  = res.first;
  assign second_value = res.second;
  assign saturated    = res.sat;
endmodule

// ===== hw/rtl/qrs_front.sv =====
// front end: discriminant magnitude, sign and root kind of one beat
module qrs_front (
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
  output qrs_pkg::item_t                    item
);
  logic [qrs_pkg::COEF_W-1:0]   mag_a, mag_b, mag_c;
  logic [2*qrs_pkg::COEF_W-1:0] bsq, ac;
  logic [qrs_pkg::DMAG_W-1:0]   bsq_x, ac4, dmag;
  logic                         ac_neg, d_neg;

  always_comb begin
    mag_a  = coef_a[qrs_pkg::COEF_W-1] ? (~coef_a + 1'b1) : coef_a;
    mag_b  = coef_b[qrs_pkg::COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
    mag_c  = coef_c[qrs_pkg::COEF_W-1] ? (~coef_c + 1'b1) : coef_c;
    bsq    = mag_b * mag_b;
    ac     = mag_a * mag_c;
    bsq_x  = {2'b00, bsq};
    ac4    = {ac, 2'b00};
    ac_neg = (coef_c != '0) && (coef_a[qrs_pkg::COEF_W-1] != coef_c[qrs_pkg::COEF_W-1]);
    d_neg  = 1'b0;
    if (ac_neg) begin
      dmag = bsq_x + ac4;
    end else if (bsq_x >= ac4) begin
      dmag = bsq_x - ac4;
    end else begin
      dmag  = ac4 - bsq_x;
      d_neg = 1'b1;
    end

    item.a    = coef_a;
    item.b    = coef_b;
    item.c    = coef_c;
    item.dmag = dmag;
    if (coef_a == '0) begin
      item.kind = (coef_b != '0) ? qrs_pkg::KIND_LINEAR : qrs_pkg::KIND_DEGENERATE;
    end else if (dmag == '0) begin
      item.kind = qrs_pkg::KIND_REPEATED;
    end else if (d_neg) begin
      item.kind = qrs_pkg::KIND_COMPLEX;
    end else begin
      item.kind = qrs_pkg::KIND_TWO_REAL;
    end
  end
endmodule

// ===== hw/rtl/qrs_queue.sv =====
// short queue of classified beats between front and back
`include "assert_macros.svh"
module qrs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  qrs_pkg::item_t wr_item,
  input  logic           rd_en,
  output qrs_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);
  qrs_pkg::item_t             mem [0:qrs_pkg::QUEUE_DEPTH-1];
  logic [qrs_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [qrs_pkg::QPTR_W:0]   cnt;

  assign full    = (cnt == (qrs_pkg::QPTR_W+1)'(qrs_pkg::QUEUE_DEPTH));
  assign empty   = (cnt == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) cnt <= cnt + 1'b1;
      else if (!wr_en && rd_en) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_item;
  end

  `QRS_ASSERT(a_q_no_overflow, wr_en, !full, "queue written while full")
  `QRS_ASSERT(a_q_no_underflow, rd_en, !empty, "queue read while empty")
  `QRS_ASSERT_NEXT(a_q_count_up, wr_en && !rd_en, cnt == $past(cnt) + 1'b1, "queue count lost a beat")
endmodule

// ===== hw/rtl/qrs_back.sv =====
// back end: pipelined square root, two pipelined dividers, saturation, result queue
`include "assert_macros.svh"
module qrs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  qrs_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output qrs_pkg::result_t res
);
  localparam int CW = qrs_pkg::COEF_W;
  localparam int DW = qrs_pkg::DMAG_W;
  localparam int RW = qrs_pkg::ROOT_W;
  localparam int MW = qrs_pkg::REM_W;
  localparam int NW = qrs_pkg::NUM_W;
  localparam int EW = qrs_pkg::DEN_W;
  localparam int OW = qrs_pkg::OUT_W;
  localparam int FW = qrs_pkg::FRAC_OUT;

  typedef struct packed {
    qrs_pkg::kind_t       kind;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic [DW-1:0]        rad;
    logic [MW-1:0]        rem;
    logic [RW-1:0]        root;
  } sq_t;

  typedef struct packed {
    qrs_pkg::kind_t       kind;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    logic signed [EW-1:0] den;
  } nu_t;

  typedef struct packed {
    qrs_pkg::kind_t kind;
    logic           neg1;
    logic           neg2;
    logic [NW-1:0]  nm1;
    logic [NW-1:0]  nm2;
    logic [NW-1:0]  q1;
    logic [NW-1:0]  q2;
    logic [EW-1:0]  r1;
    logic [EW-1:0]  r2;
    logic [EW-1:0]  dm;
  } dv_t;

  // one result bit of the root per stage, two radicand bits shifted in
  function automatic sq_t sq_step(input sq_t s, input logic use_rad);
    sq_t        o;
    logic [1:0] pair;
    logic [MW-1:0] sh, trial;
    o     = s;
    pair  = use_rad ? s.rad[DW-1 -: 2] : 2'b00;
    sh    = {s.rem[MW-3:0], pair};
    trial = {s.root, 2'b01};
    if (sh >= trial) begin
      o.rem  = sh - trial;
      o.root = {s.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = sh;
      o.root = {s.root[RW-2:0], 1'b0};
    end
    o.rad = {s.rad[DW-3:0], 2'b00};
    return o;
  endfunction

  function automatic nu_t nu_make(input sq_t s);
    nu_t                  o;
    logic signed [NW-1:0] bx, cx, nb, sx;
    logic signed [EW-1:0] two_a, bden, one;
    bx    = {{(NW-CW-FW){s.b[CW-1]}}, s.b, {FW{1'b0}}};
    cx    = {{(NW-CW-FW){s.c[CW-1]}}, s.c, {FW{1'b0}}};
    nb    = -bx;
    sx    = {{(NW-RW){1'b0}}, s.root};
    two_a = {s.a, 1'b0};
    bden  = {s.b[CW-1], s.b};
    one   = {{(EW-1){1'b0}}, 1'b1};
    o.kind = s.kind;
    unique case (s.kind)
      qrs_pkg::KIND_LINEAR: begin
        o.n1 = -cx;      o.n2 = '0; o.den = bden;
      end
      qrs_pkg::KIND_REPEATED: begin
        o.n1 = nb;       o.n2 = '0; o.den = two_a;
      end
      qrs_pkg::KIND_TWO_REAL: begin
        o.n1 = nb + sx;  o.n2 = nb - sx; o.den = two_a;
      end
      qrs_pkg::KIND_COMPLEX: begin
        o.n1 = nb;       o.n2 = sx; o.den = two_a;
      end
      qrs_pkg::KIND_DEGENERATE: begin
        o.n1 = '0;       o.n2 = '0; o.den = one;
      end
      default: begin
        o.n1 = '0;       o.n2 = '0; o.den = one;
      end
    endcase
    return o;
  endfunction

  function automatic dv_t dv_load(input nu_t n);
    dv_t  o;
    logic dneg;
    dneg   = n.den[EW-1];
    o.kind = n.kind;
    o.neg1 = n.n1[NW-1] ^ dneg;
    o.neg2 = n.n2[NW-1] ^ dneg;
    o.nm1  = n.n1[NW-1] ? (~n.n1 + 1'b1) : n.n1;
    o.nm2  = n.n2[NW-1] ? (~n.n2 + 1'b1) : n.n2;
    o.dm   = dneg ? (~n.den + 1'b1) : n.den;
    o.q1   = '0;
    o.q2   = '0;
    o.r1   = '0;
    o.r2   = '0;
    return o;
  endfunction

  // restoring division, one quotient bit per stage in both lanes
  function automatic dv_t dv_step(input dv_t s);
    dv_t        o;
    logic [EW:0] sh1, sh2, df1, df2, dmx;
    logic       ge1, ge2;
    o   = s;
    dmx = {1'b0, s.dm};
    sh1 = {s.r1, s.nm1[NW-1]};
    sh2 = {s.r2, s.nm2[NW-1]};
    df1 = sh1 - dmx;
    df2 = sh2 - dmx;
    ge1 = (sh1 >= dmx);
    ge2 = (sh2 >= dmx);
    o.r1  = ge1 ? df1[EW-1:0] : sh1[EW-1:0];
    o.r2  = ge2 ? df2[EW-1:0] : sh2[EW-1:0];
    o.q1  = {s.q1[NW-2:0], ge1};
    o.q2  = {s.q2[NW-2:0], ge2};
    o.nm1 = {s.nm1[NW-2:0], 1'b0};
    o.nm2 = {s.nm2[NW-2:0], 1'b0};
    return o;
  endfunction

  // {clipped, value} of a signed quotient given as sign and magnitude
  function automatic logic [OW:0] clip(input logic neg, input logic [NW-1:0] q);
    logic          over;
    logic [OW-1:0] val;
    if (neg) begin
      over = (|q[NW-1:OW]) || (q[OW-1] && (|q[OW-2:0]));
      val  = over ? {1'b1, {(OW-1){1'b0}}} : (~q[OW-1:0] + 1'b1);
    end else begin
      over = |q[NW-1:OW-1];
      val  = over ? {1'b0, {(OW-1){1'b1}}} : q[OW-1:0];
    end
    return {over, val};
  endfunction

  sq_t  sq_p [0:RW];
  logic sq_v [0:RW];
  nu_t  nu_p;
  logic nu_v;
  dv_t  dv_p [0:NW];
  logic dv_v [0:NW];
  logic adv;

  qrs_pkg::result_t oq_mem [0:1];
  logic             oq_wp, oq_rp;
  logic [1:0]       oq_cnt;
  logic             oq_full, oq_wr, oq_rd;
  qrs_pkg::result_t oq_in;
  logic [OW:0]      c1, c2;

  // the whole pipe moves together; it holds only when the last beat has nowhere to go
  assign adv   = !dv_v[NW] || !oq_full;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= RW; i++) sq_v[i] <= 1'b0;
      nu_v <= 1'b0;
      for (int i = 0; i <= NW; i++) dv_v[i] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= !q_empty;
      for (int i = 0; i < RW; i++) sq_v[i+1] <= sq_v[i];
      nu_v    <= sq_v[RW];
      dv_v[0] <= nu_v;
      for (int i = 0; i < NW; i++) dv_v[i+1] <= dv_v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_p[0].kind <= q_item.kind;
      sq_p[0].a    <= q_item.a;
      sq_p[0].b    <= q_item.b;
      sq_p[0].c    <= q_item.c;
      sq_p[0].rad  <= q_item.dmag;
      sq_p[0].rem  <= '0;
      sq_p[0].root <= '0;
      for (int i = 0; i < RW; i++) sq_p[i+1] <= sq_step(sq_p[i], i < DW / 2);
      nu_p    <= nu_make(sq_p[RW]);
      dv_p[0] <= dv_load(nu_p);
      for (int i = 0; i < NW; i++) dv_p[i+1] <= dv_step(dv_p[i]);
    end
  end

  always_comb begin
    c1           = clip(dv_p[NW].neg1, dv_p[NW].q1);
    c2           = clip(dv_p[NW].neg2, dv_p[NW].q2);
    oq_in.kind   = dv_p[NW].kind;
    oq_in.first  = c1[OW-1:0];
    oq_in.second = c2[OW-1:0];
    oq_in.sat    = c1[OW] | c2[OW];
  end

  assign oq_full = (oq_cnt == 2'd2);
  assign empty   = (oq_cnt == 2'd0);
  assign oq_wr   = adv && dv_v[NW];
  assign oq_rd   = pop && !empty;
  assign res     = oq_mem[oq_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= 1'b0;
      oq_rp  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (oq_wr) oq_wp <= ~oq_wp;
      if (oq_rd) oq_rp <= ~oq_rp;
      if (oq_wr && !oq_rd) oq_cnt <= oq_cnt + 1'b1;
      else if (!oq_wr && oq_rd) oq_cnt <= oq_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) oq_mem[oq_wp] <= oq_in;
  end

  `QRS_ASSERT(a_oq_bound, 1'b1, oq_cnt != 2'd3, "result queue count out of range")
  `QRS_ASSERT_NEXT(a_stall_holds, dv_v[NW] && !adv, dv_v[NW], "stalled beat dropped from pipe")
  `QRS_ASSERT(a_degen_zero, !empty && (res.kind == qrs_pkg::KIND_DEGENERATE), (res.first == '0) && (res.second == '0) && !res.sat, "degenerate beat with nonzero result")
endmodule
